// ===== design/utm_pkg.sv =====
// Shared constants, types and codes of the UTF-8 text width measurer.
`timescale 1ns / 1ps
package utm_pkg;

    localparam int MAX_GLYPHS = 256;
    localparam int WIDTH_BITS = 24;

    localparam int GI_W = $clog2(MAX_GLYPHS);
    localparam int SI_W = GI_W + 2;
    localparam logic [WIDTH_BITS-1:0] SUM_MAX = {WIDTH_BITS{1'b1}};

    localparam logic [20:0] REPL_CP = 21'h00FFFD;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [1:0] REG_TABLE_ENTRIES = 2'd0;
    localparam logic [1:0] REG_FONT_ASCENT   = 2'd1;
    localparam logic [1:0] REG_TEXT_SCALE    = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ADD,
        OP_EMIT
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  idx;
        logic [20:0] cp;
        logic [7:0]  adv;
    } op_t;

    typedef struct packed {
        logic [8:0] table_entries;
        logic [7:0] font_ascent;
        logic [7:0] text_scale;
    } cfg_t;

endpackage

// ===== design/utm_if.sv =====
// Request, result and configuration channel interfaces.
`timescale 1ns / 1ps
interface utm_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  entry_index;
    logic [20:0] entry_codepoint;
    logic [7:0]  entry_advance;
    logic [7:0]  text_byte;
    logic        text_last;

    modport source (output valid, req_type, entry_index, entry_codepoint, entry_advance,
                    text_byte, text_last, input ready);
    modport sink (input valid, req_type, entry_index, entry_codepoint, entry_advance,
                  text_byte, text_last, output ready);
endinterface

interface utm_res_if;
    logic        valid;
    logic        ready;
    logic [23:0] text_width;
    logic        width_saturated;

    modport source (output valid, text_width, width_saturated, input ready);
    modport sink (input valid, text_width, width_saturated, output ready);
endinterface

interface utm_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/utf8_text_width_measurer.sv =====
// Top level of the UTF-8 text width measurer: config registers, decoder, queue, lookup.
//
//  channel | dir | handshake          | payload
//  req     | in  | req.valid/ready    | req_type, entry_index, entry_codepoint,
//          |     |                    | entry_advance, text_byte, text_last
//  res     | out | res.valid/ready    | text_width, width_saturated
//  cfg     | in  | cfg.valid/ready    | index, data
//
// The decoder takes a request, then pushes its ops one per cycle while the queue has room,
// before taking the next: one op for a glyph load, up to three for a text byte.
// Back end: a load or emit is taken from idle; an add runs a binary search of up to 9
// probes on a full table (probe, compare), falls back to half the font ascent when the
// glyph is missing, then scales and sums. Reset clears decoder, sum and queue; the
// glyph table is not cleared. The 4-entry op queue lets the decoder run ahead; a held
// result stalls only the emit op.
`timescale 1ns / 1ps
module utf8_text_width_measurer (
    input  logic      clk,
    input  logic      rst_n,
    utm_req_if.sink   req,
    utm_res_if.source res,
    utm_cfg_if.sink   cfg
);
    import utm_pkg::*;

    cfg_t cfg_reg;
    logic push_valid, push_ready, pop_valid, pop_ready;
    op_t  push_op, pop_op;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.table_entries <= 9'd0;
            cfg_reg.font_ascent   <= 8'd0;
            cfg_reg.text_scale    <= 8'd1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_TABLE_ENTRIES: cfg_reg.table_entries <= cfg.data;
                REG_FONT_ASCENT:   cfg_reg.font_ascent   <= cfg.data[7:0];
                REG_TEXT_SCALE:    cfg_reg.text_scale    <= cfg.data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    utm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    utm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_op     (push_op),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_op    (pop_op)
    );

    utm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_reg),
        .op_valid (pop_valid),
        .op_ready (pop_ready),
        .op       (pop_op),
        .res      (res)
    );

endmodule

// ===== design/utm_front.sv =====
// Front end: accepts requests, decodes UTF-8 and queues table, lookup and emit ops.
`timescale 1ns / 1ps
module utm_front (
    input  logic          clk,
    input  logic          rst_n,
    utm_req_if.sink       req,
    output logic          push_valid,
    input  logic          push_ready,
    output utm_pkg::op_t  push_op
);
    import utm_pkg::*;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    logic [1:0]  pend_reg, pend_next;
    logic [20:0] part_reg, part_next;
    logic        ended_reg, ended_next;
    op_t         slot_reg [3];
    op_t         slot_next [3];
    logic [1:0]  cnt_reg, cnt_next;

    logic        acc;
    logic [7:0]  b;

    assign req.ready  = (cnt_reg == 2'd0);
    assign acc        = req.valid && req.ready;
    assign push_valid = (cnt_reg != 2'd0);
    assign push_op    = slot_reg[0];
    assign b          = req.text_byte;

    always_comb
    begin
        pend_next  = pend_reg;
        part_next  = part_reg;
        ended_next = ended_reg;
        cnt_next   = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            slot_next[i]      = '0;
            slot_next[i].kind = OP_ADD;
        end
        if (!req.req_type)
        begin
            slot_next[0].kind = OP_LOAD;
            slot_next[0].idx  = req.entry_index;
            slot_next[0].cp   = req.entry_codepoint;
            slot_next[0].adv  = req.entry_advance;
            cnt_next          = 2'd1;
        end
        else
        begin
            if (!ended_reg)
            begin
                if (b == 8'd0)
                begin
                    if (pend_reg != 2'd0)
                    begin
                        slot_next[cnt_next].cp = REPL_CP;
                        cnt_next = cnt_next + 2'd1;
                    end
                    pend_next  = 2'd0;
                    part_next  = '0;
                    ended_next = 1'b1;
                end
                else if (pend_reg != 2'd0 && (b & CONT_MASK) == CONT_CODE)
                begin
                    part_next = {part_reg[14:0], b[5:0]};
                    pend_next = pend_reg - 2'd1;
                    if (pend_next == 2'd0)
                    begin
                        slot_next[cnt_next].cp = part_next;
                        cnt_next  = cnt_next + 2'd1;
                        part_next = '0;
                    end
                end
                else
                begin
                    if (pend_reg != 2'd0)
                    begin
                        slot_next[cnt_next].cp = REPL_CP;
                        cnt_next  = cnt_next + 2'd1;
                        pend_next = 2'd0;
                        part_next = '0;
                    end
                    priority if (b[7] == 1'b0)
                    begin
                        slot_next[cnt_next].cp = {13'd0, b};
                        cnt_next = cnt_next + 2'd1;
                    end
                    else if ((b & LEAD2_MASK) == LEAD2_CODE)
                    begin
                        part_next = {16'd0, b[4:0]};
                        pend_next = 2'd1;
                    end
                    else if ((b & LEAD3_MASK) == LEAD3_CODE)
                    begin
                        part_next = {17'd0, b[3:0]};
                        pend_next = 2'd2;
                    end
                    else if ((b & LEAD4_MASK) == LEAD4_CODE)
                    begin
                        part_next = {18'd0, b[2:0]};
                        pend_next = 2'd3;
                    end
                    else
                    begin
                        slot_next[cnt_next].cp = REPL_CP;
                        cnt_next = cnt_next + 2'd1;
                    end
                end
            end
            if (req.text_last)
            begin
                if (pend_next != 2'd0)
                begin
                    slot_next[cnt_next].cp = REPL_CP;
                    cnt_next = cnt_next + 2'd1;
                end
                slot_next[cnt_next].kind = OP_EMIT;
                cnt_next   = cnt_next + 2'd1;
                pend_next  = 2'd0;
                part_next  = '0;
                ended_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 2'd0;
            part_reg  <= '0;
            ended_reg <= 1'b0;
            cnt_reg   <= 2'd0;
        end
        else if (acc)
        begin
            pend_reg  <= pend_next;
            part_reg  <= part_next;
            ended_reg <= ended_next;
            cnt_reg   <= cnt_next;
        end
        else if (push_valid && push_ready)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            slot_reg <= slot_next;
        end
        else if (push_valid && push_ready)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    // end of string always leaves a clean decoder
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && req.req_type && req.text_last) |=> (pend_reg == 2'd0 && !ended_reg))
        else $error("decoder state not cleared after last byte");

endmodule

// ===== design/utm_queue.sv =====
// Small op queue between the decoder and the lookup engine.
`timescale 1ns / 1ps
module utm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  utm_pkg::op_t  in_op,
    output logic          out_valid,
    input  logic          out_ready,
    output utm_pkg::op_t  out_op
);
    import utm_pkg::*;

    op_t           mem [Q_DEPTH];
    logic [Q_AW-1:0] wp_reg, rp_reg;
    logic [Q_AW:0]   cnt_reg;
    logic            push, pop;

    assign in_ready  = (cnt_reg != (Q_AW+1)'(Q_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_op    = mem[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rp_reg <= rp_reg + Q_AW'(1);
            end
            cnt_reg <= cnt_reg + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= in_op;
        end
    end

endmodule

// ===== design/utm_back.sv =====
// Back end: glyph table, binary search, scaling, saturating sum and result register.
`timescale 1ns / 1ps
module utm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  utm_pkg::cfg_t cfg_regs,
    input  logic          op_valid,
    output logic          op_ready,
    input  utm_pkg::op_t  op,
    utm_res_if.source     res
);
    import utm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_MUL,
        ST_ACC
    } state_t;

    typedef struct packed {
        logic [20:0] cp;
        logic [7:0]  adv;
    } glyph_t;

    localparam logic signed [SI_W-1:0] ONE_S = 1;

    glyph_t                 glyph_mem [MAX_GLYPHS];
    glyph_t                 rd_reg;
    state_t                 state_reg;
    logic signed [SI_W-1:0] lo_reg, hi_reg, mid_reg;
    logic signed [SI_W-1:0] mid_c, n_s;
    logic [20:0]            cp_reg;
    logic [7:0]             adv_reg;
    logic [15:0]            prod_reg;
    logic [WIDTH_BITS-1:0]  sum_reg;
    logic                   clip_reg;
    logic                   res_valid_reg;
    logic [23:0]            width_reg;
    logic                   sat_reg;
    logic [7:0]             scale_eff;
    logic [WIDTH_BITS:0]    sum_c;
    logic                   take, wr_en, rd_en, out_free;

    assign n_s       = (32'(cfg_regs.table_entries) > MAX_GLYPHS) ? SI_W'(MAX_GLYPHS)
                                                                  : SI_W'(cfg_regs.table_entries);
    assign mid_c     = (lo_reg + hi_reg) >>> 1;
    assign scale_eff = (cfg_regs.text_scale == 8'd0) ? 8'd1 : cfg_regs.text_scale;
    assign sum_c     = {1'b0, sum_reg} + (WIDTH_BITS+1)'(prod_reg);
    assign out_free  = !res_valid_reg || res.ready;
    assign op_ready  = (state_reg == ST_IDLE) && (op.kind != OP_EMIT || out_free);
    assign take      = op_valid && op_ready;
    assign wr_en     = take && op.kind == OP_LOAD && 32'(op.idx) < MAX_GLYPHS;
    assign rd_en     = (state_reg == ST_PROBE) && (lo_reg <= hi_reg);

    assign res.valid           = res_valid_reg;
    assign res.text_width      = width_reg;
    assign res.width_saturated = sat_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            glyph_mem[GI_W'(op.idx)] <= '{cp: op.cp, adv: op.adv};
        end
        if (rd_en)
        begin
            rd_reg <= glyph_mem[mid_c[GI_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            clip_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            cp_reg        <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            adv_reg       <= '0;
            prod_reg      <= '0;
            width_reg     <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            if (take && op.kind == OP_EMIT)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        unique case (op.kind)
                            OP_ADD:
                            begin
                                cp_reg    <= op.cp;
                                lo_reg    <= '0;
                                hi_reg    <= n_s - ONE_S;
                                state_reg <= ST_PROBE;
                            end
                            OP_EMIT:
                            begin
                                width_reg     <= 24'(sum_reg);
                                sat_reg       <= clip_reg;
                                sum_reg       <= '0;
                                clip_reg      <= 1'b0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_PROBE:
                begin
                    if (lo_reg <= hi_reg)
                    begin
                        mid_reg   <= mid_c;
                        state_reg <= ST_CMP;
                    end
                    else
                    begin
                        adv_reg   <= cfg_regs.font_ascent >> 1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_CMP:
                begin
                    priority if (rd_reg.cp == cp_reg)
                    begin
                        adv_reg   <= rd_reg.adv;
                        state_reg <= ST_MUL;
                    end
                    else if (rd_reg.cp < cp_reg)
                    begin
                        lo_reg    <= mid_reg + ONE_S;
                        state_reg <= ST_PROBE;
                    end
                    else
                    begin
                        hi_reg    <= mid_reg - ONE_S;
                        state_reg <= ST_PROBE;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= 16'(adv_reg) * 16'(scale_eff);
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (sum_c >= (WIDTH_BITS+1)'(SUM_MAX))
                    begin
                        sum_reg  <= SUM_MAX;
                        clip_reg <= 1'b1;
                    end
                    else
                    begin
                        sum_reg <= sum_c[WIDTH_BITS-1:0];
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (mid_reg >= 0 && mid_reg < n_s))
        else $error("search probe outside the table");

    a_clip_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        clip_reg |-> (sum_reg == SUM_MAX))
        else $error("saturation flag set below maximum");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && op.kind == OP_EMIT) |=> (sum_reg == '0 && !clip_reg && res_valid_reg))
        else $error("sum not cleared on emit");

endmodule
